// File: design/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and sizes of the indexed list store: command and status codes,
// sequencer states and the storage dimensions.
// ----------------------------------------------------------------------------
package ils_pkg;

  // storage dimensions
  localparam int unsigned Capacity = 64;
  localparam int unsigned WordW    = 32;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned LenW     = $clog2(Capacity + 1);

  // field widths of the request and the result
  localparam int unsigned CmdW    = 3;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_GET    = 3'd0,
    CMD_SET    = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_REMOVE = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_GET   = 2'd1,
    S_SHIFT = 2'd2
  } state_e;

endpackage

// File: design/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Simple dual-port RAM: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/indexed_list_store.sv
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of data words with a length count, kept in one RAM.
// ----------------------------------------------------------------------------
// A request (command_i, index_i, data_i) is taken on a rising edge with start
// high and busy low. Each request gives one result on status_o, read_data_o
// and length_o, valid for the single cycle in which done_o is high; the
// receiver cannot stall, so it must sample the result in that cycle.
// Set, append, clear, unused codes and any error report straight from idle
// and busy stays low; get passes through one RAM read in the get state;
// insert before and remove run the shift state, which moves used - index
// words for insert and used - index - 1 for remove (none when the last word
// is removed).
// Insert and remove move one word per cycle through the RAM, one read and one
// write in flight.
// Quick commands may follow each other in every cycle.
// Reset clears the length to zero and returns to idle; the RAM contents are
// not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
module indexed_list_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ils_pkg::CmdW-1:0]   command_i,
  input  logic [ils_pkg::IndexW-1:0] index_i,
  input  logic [ils_pkg::WordW-1:0]  data_i,
  output logic                       done_o,
  output logic [ils_pkg::StatusW-1:0] status_o,
  output logic [ils_pkg::WordW-1:0]  read_data_o,
  output logic [ils_pkg::LenW-1:0]   length_o
);

  import ils_pkg::*;

  state_e            state_q, state_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [WordW-1:0]  rdata_q, rdata_d;

  // shift sequencer registers
  logic              ins_q, ins_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [LenW-1:0]   remain_q, remain_d;
  logic              pend_q, pend_d;
  logic [AddrW-1:0]  pend_addr_q, pend_addr_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [WordW-1:0]  data_q, data_d;

  // ram ports
  logic              ram_we, ram_re;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [WordW-1:0]  ram_wdata, ram_rdata;

  logic              accept;
  logic              idx_ok;
  logic              full;
  logic              shift_end;
  logic [LenW-1:0]   idx_ext;

  assign accept    = start && (state_q == S_IDLE);
  assign idx_ext   = LenW'(index_i);
  assign idx_ok    = idx_ext < len_q;
  assign full      = len_q == LenW'(Capacity);
  assign shift_end = (remain_q == '0) && !pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          priority if (cmd_e'(command_i) == CMD_GET && idx_ok) begin
            state_d = S_GET;
          end else if (cmd_e'(command_i) == CMD_INSERT && idx_ok && !full) begin
            state_d = S_SHIFT;
          end else if (cmd_e'(command_i) == CMD_REMOVE && idx_ok) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_GET:   state_d = S_IDLE;
      S_SHIFT: begin
        if (shift_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    len_d       = len_q;
    done_d      = 1'b0;
    status_d    = ST_OK;
    rdata_d     = '0;
    ins_d       = ins_q;
    ptr_d       = ptr_q;
    remain_d    = remain_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    idx_d       = idx_q;
    data_d      = data_q;
    ram_we      = 1'b0;
    ram_waddr   = AddrW'(index_i);
    ram_wdata   = data_i;
    ram_re      = 1'b0;
    ram_raddr   = AddrW'(index_i);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d  = AddrW'(index_i);
          data_d = data_i;
          unique case (command_i)
            CMD_GET: begin
              if (idx_ok) begin
                ram_re = 1'b1;
              end else begin
                done_d   = 1'b1;
                status_d = ST_BAD_INDEX;
              end
            end
            CMD_SET: begin
              done_d = 1'b1;
              if (idx_ok) begin
                ram_we = 1'b1;
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            CMD_APPEND: begin
              done_d = 1'b1;
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AddrW'(len_q);
                len_d     = len_q + LenW'(1);
              end
            end
            CMD_INSERT: begin
              priority if (!idx_ok) begin
                done_d   = 1'b1;
                status_d = ST_BAD_INDEX;
              end else if (full) begin
                done_d   = 1'b1;
                status_d = ST_FULL;
              end else begin
                // move words from the top down to index
                ins_d    = 1'b1;
                ptr_d    = AddrW'(len_q - LenW'(1));
                remain_d = len_q - idx_ext;
                len_d    = len_q + LenW'(1);
              end
            end
            CMD_REMOVE: begin
              if (!idx_ok) begin
                done_d   = 1'b1;
                status_d = ST_BAD_INDEX;
              end else begin
                // move words above index down by one
                ins_d    = 1'b0;
                ptr_d    = AddrW'(idx_ext + LenW'(1));
                remain_d = len_q - idx_ext - LenW'(1);
                len_d    = len_q - LenW'(1);
              end
            end
            CMD_CLEAR: begin
              done_d = 1'b1;
              len_d  = '0;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_GET: begin
        done_d  = 1'b1;
        rdata_d = ram_rdata;
      end

      S_SHIFT: begin
        // issue the next read of the shift
        if (remain_q != '0) begin
          ram_re      = 1'b1;
          ram_raddr   = ptr_q;
          remain_d    = remain_q - LenW'(1);
          ptr_d       = ins_q ? ptr_q - AddrW'(1) : ptr_q + AddrW'(1);
          pend_d      = 1'b1;
          pend_addr_d = ptr_q;
        end
        // write back the word read last cycle one place over
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = ins_q ? pend_addr_q + AddrW'(1) : pend_addr_q - AddrW'(1);
          ram_wdata = ram_rdata;
        end
        // shift done: place the new word for insert and report
        if (shift_end) begin
          done_d = 1'b1;
          if (ins_q) begin
            ram_we    = 1'b1;
            ram_waddr = idx_q;
            ram_wdata = data_q;
          end
        end
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      len_q    <= '0;
      done_q   <= 1'b0;
      remain_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      len_q    <= len_d;
      done_q   <= done_d;
      remain_q <= remain_d;
      pend_q   <= pend_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    rdata_q     <= rdata_d;
    ins_q       <= ins_d;
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    idx_q       <= idx_d;
    data_q      <= data_d;
  end

  // word storage
  ils_ram #(
    .Depth(Capacity),
    .Width(WordW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign busy        = state_q != S_IDLE;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_data_o = rdata_q;
  assign length_o    = len_q;

endmodule
